// ----- sv/tlne_pkg.sv -----
package tlne_pkg;

   localparam int MAX_DEPTH   = 63;
   localparam int DEPTH_COUNT = MAX_DEPTH + 1;
   localparam int DEPTH_W     = $clog2(DEPTH_COUNT);
   localparam int INDEX_W     = 16;
   localparam int MOVE_W      = 3;
   localparam int MOVE_COUNT  = 6;

   // Move codes: first letter gains one, second letter loses one
   localparam logic [MOVE_W-1:0] MOVE_AB = 3'd0;
   localparam logic [MOVE_W-1:0] MOVE_AC = 3'd1;
   localparam logic [MOVE_W-1:0] MOVE_AD = 3'd2;
   localparam logic [MOVE_W-1:0] MOVE_BC = 3'd3;
   localparam logic [MOVE_W-1:0] MOVE_BD = 3'd4;
   localparam logic [MOVE_W-1:0] MOVE_CD = 3'd5;

   typedef logic [INDEX_W-1:0] count_table_type [DEPTH_COUNT];

   typedef enum logic [1:0] {
      FRONT_IDLE,
      FRONT_SCAN_A,
      FRONT_SCAN_B,
      FRONT_PUSH
   } front_state_type;

   // One classified vertex handed from the front to the back
   typedef struct packed {
      logic               err;
      logic [DEPTH_W-1:0] a;
      logic [DEPTH_W-1:0] b;
      logic [DEPTH_W-1:0] c;
      logic [DEPTH_W-1:0] d;
      logic [DEPTH_W-1:0] rem;
      logic [DEPTH_W-1:0] rb;
      logic [INDEX_W-1:0] rank;
      logic [INDEX_W-1:0] rank_t;
   } entry_type;

   typedef struct packed {
      logic      valid;
      entry_type entry;
   } queue_port_type;

   // Points in a triangle slab of side r: (r+2)(r+1)/2, built by running sums
   function automatic count_table_type build_tri_table();
      count_table_type t;
      t[0] = INDEX_W'(1);
      for (int r = 1; r < DEPTH_COUNT; r++) begin
         t[r] = t[r-1] + INDEX_W'(r + 1);
      end
      return t;
   endfunction

   // Points in the whole tetrahedron of depth r
   function automatic count_table_type build_tet_table();
      count_table_type t;
      count_table_type s;
      t = build_tri_table();
      s[0] = INDEX_W'(1);
      for (int r = 1; r < DEPTH_COUNT; r++) begin
         s[r] = s[r-1] + t[r];
      end
      return s;
   endfunction

   localparam count_table_type TRI_TABLE = build_tri_table();
   localparam count_table_type TET_TABLE = build_tet_table();

endpackage

// ----- sv/tlne_front.sv -----
module tlne_front
   import tlne_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [INDEX_W-1:0]   req_vertex_index,
   input  logic [DEPTH_W-1:0]   depth,
   input  logic                 queue_full,
   output queue_port_type       push
);

   front_state_type    state_ff, state_in;
   logic [INDEX_W-1:0] idx_ff, idx_in;
   logic [INDEX_W-1:0] rank_ff, rank_in;
   logic [INDEX_W-1:0] tri_ff, tri_in;
   logic [DEPTH_W-1:0] a_ff, a_in;
   logic [DEPTH_W-1:0] rem_ff, rem_in;
   logic [DEPTH_W-1:0] b_ff, b_in;
   logic [DEPTH_W-1:0] rb_ff, rb_in;
   logic               err_ff, err_in;

   logic               accept;
   logic               out_of_range;
   logic [INDEX_W-1:0] a_blk;
   logic [INDEX_W-1:0] b_blk;
   logic               a_hit;
   logic               b_hit;
   logic [DEPTH_W-1:0] c_val;

   assign accept       = req_valid && !req_stall;
   assign out_of_range = req_vertex_index >= TET_TABLE[depth];
   assign a_blk        = TRI_TABLE[rem_ff];
   assign b_blk        = INDEX_W'(rb_ff) + INDEX_W'(1);
   assign a_hit        = idx_ff < a_blk;
   assign b_hit        = idx_ff < b_blk;
   assign c_val        = idx_ff[DEPTH_W-1:0];

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         FRONT_IDLE: begin
            if (accept) begin
               state_in = out_of_range ? FRONT_PUSH : FRONT_SCAN_A;
            end
         end
         FRONT_SCAN_A: begin
            if (a_hit) begin
               state_in = FRONT_SCAN_B;
            end
         end
         FRONT_SCAN_B: begin
            if (b_hit) begin
               state_in = FRONT_PUSH;
            end
         end
         FRONT_PUSH: begin
            if (!queue_full) begin
               state_in = FRONT_IDLE;
            end
         end
         default: state_in = FRONT_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      req_stall         = (state_ff != FRONT_IDLE);
      push.valid        = (state_ff == FRONT_PUSH) && !queue_full;
      push.entry.err    = err_ff;
      push.entry.a      = a_ff;
      push.entry.b      = b_ff;
      push.entry.c      = c_val;
      push.entry.d      = rb_ff - c_val;
      push.entry.rem    = rem_ff;
      push.entry.rb     = rb_ff;
      push.entry.rank   = rank_ff;
      push.entry.rank_t = rank_ff + tri_ff;
   end

   // Datapath: peel slabs, then rows, off the index, one per cycle
   always_comb begin
      idx_in  = idx_ff;
      rank_in = rank_ff;
      tri_in  = tri_ff;
      a_in    = a_ff;
      rem_in  = rem_ff;
      b_in    = b_ff;
      rb_in   = rb_ff;
      err_in  = err_ff;
      case (state_ff)
         FRONT_IDLE: begin
            idx_in  = req_vertex_index;
            rank_in = req_vertex_index;
            a_in    = '0;
            rem_in  = depth;
            b_in    = '0;
            rb_in   = depth;
            err_in  = out_of_range;
         end
         FRONT_SCAN_A: begin
            if (a_hit) begin
               tri_in = a_blk;
               rb_in  = rem_ff;
               b_in   = '0;
            end else begin
               idx_in = idx_ff - a_blk;
               a_in   = a_ff + DEPTH_W'(1);
               rem_in = rem_ff - DEPTH_W'(1);
            end
         end
         FRONT_SCAN_B: begin
            if (!b_hit) begin
               idx_in = idx_ff - b_blk;
               b_in   = b_ff + DEPTH_W'(1);
               rb_in  = rb_ff - DEPTH_W'(1);
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FRONT_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff  <= idx_in;
      rank_ff <= rank_in;
      tri_ff  <= tri_in;
      a_ff    <= a_in;
      rem_ff  <= rem_in;
      b_ff    <= b_in;
      rb_ff   <= rb_in;
      err_ff  <= err_in;
   end

endmodule

// ----- sv/tlne_queue.sv -----
module tlne_queue
   import tlne_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  queue_port_type push,
   output logic           full,
   output queue_port_type head,
   input  logic           pop
);

   entry_type  slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push;
   logic       do_pop;

   assign full       = (count_ff == 2'd2);
   assign do_push    = push.valid && !full;
   assign do_pop     = pop && (count_ff != 2'd0);
   assign head.valid = (count_ff != 2'd0);
   assign head.entry = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      count_in  = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push.entry;
      end
   end

endmodule

// ----- sv/tlne_back.sv -----
module tlne_back
   import tlne_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  queue_port_type       head,
   output logic                 pop,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [DEPTH_W-1:0]   rsp_coord_a,
   output logic [DEPTH_W-1:0]   rsp_coord_b,
   output logic [DEPTH_W-1:0]   rsp_coord_c,
   output logic [DEPTH_W-1:0]   rsp_coord_d,
   output logic [INDEX_W-1:0]   rsp_neighbor_index,
   output logic [MOVE_W-1:0]    rsp_move_code,
   output logic                 rsp_has_edge,
   output logic                 rsp_index_error,
   output logic                 rsp_last_result
);

   entry_type               e;
   logic [MOVE_W-1:0]       move_ff, move_in;
   logic [MOVE_COUNT-1:0]   mask;
   logic                    single;
   logic                    cur;
   logic                    last;
   logic                    can_load;
   logic                    emit;
   logic signed [7:0]       off;
   logic [INDEX_W-1:0]      base;
   logic [INDEX_W-1:0]      nb;

   logic                    valid_ff, valid_in;
   logic [DEPTH_W-1:0]      ca_ff, ca_in, cb_ff, cb_in, cc_ff, cc_in, cd_ff, cd_in;
   logic [INDEX_W-1:0]      nb_ff, nb_in;
   logic [MOVE_W-1:0]       mv_ff, mv_in;
   logic                    edge_ff, edge_in;
   logic                    err_ff, err_in;
   logic                    last_ff, last_in;

   assign e = head.entry;

   always_comb begin
      mask = {e.d != '0, e.d != '0, e.c != '0, e.d != '0, e.c != '0, e.b != '0};
      single   = e.err || (mask == '0);
      cur      = mask[move_ff];
      last     = (mask & MOVE_COUNT'(6'b111110 << move_ff)) == '0;
      can_load = !valid_ff || !rsp_stall;
      emit     = head.valid && can_load && (single || cur);
      pop      = head.valid && can_load && (single || (cur && last));
   end

   // Neighbour rank as a small offset from the source rank
   always_comb begin
      base = e.rank;
      off  = '0;
      case (move_ff)
         MOVE_AB: begin
            base = e.rank_t;
            off  = -$signed({2'b00, e.rem}) - 8'sd1;
         end
         MOVE_AC: begin
            base = e.rank_t;
            off  = -$signed({2'b00, e.b}) - 8'sd1;
         end
         MOVE_AD: begin
            base = e.rank_t;
            off  = -$signed({2'b00, e.b});
         end
         MOVE_BC: off = $signed({2'b00, e.rb});
         MOVE_BD: off = $signed({2'b00, e.rb}) + 8'sd1;
         MOVE_CD: off = 8'sd1;
         default: off = '0;
      endcase
      nb = base + {{(INDEX_W-8){off[7]}}, off};
   end

   always_comb begin
      move_in = move_ff;
      if (pop) begin
         move_in = '0;
      end else if (head.valid && !single && (!cur || can_load)) begin
         move_in = move_ff + MOVE_W'(1);
      end
   end

   always_comb begin
      valid_in = valid_ff;
      ca_in    = ca_ff;
      cb_in    = cb_ff;
      cc_in    = cc_ff;
      cd_in    = cd_ff;
      nb_in    = nb_ff;
      mv_in    = mv_ff;
      edge_in  = edge_ff;
      err_in   = err_ff;
      last_in  = last_ff;
      if (can_load) begin
         valid_in = emit;
         ca_in    = e.err ? '0 : e.a;
         cb_in    = e.err ? '0 : e.b;
         cc_in    = e.err ? '0 : e.c;
         cd_in    = e.err ? '0 : e.d;
         nb_in    = single ? '0 : nb;
         mv_in    = single ? MOVE_AB : move_ff;
         edge_in  = !single;
         err_in   = e.err;
         last_in  = single || last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         move_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         move_ff  <= move_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ca_ff   <= ca_in;
      cb_ff   <= cb_in;
      cc_ff   <= cc_in;
      cd_ff   <= cd_in;
      nb_ff   <= nb_in;
      mv_ff   <= mv_in;
      edge_ff <= edge_in;
      err_ff  <= err_in;
      last_ff <= last_in;
   end

   assign rsp_valid          = valid_ff;
   assign rsp_coord_a        = ca_ff;
   assign rsp_coord_b        = cb_ff;
   assign rsp_coord_c        = cc_ff;
   assign rsp_coord_d        = cd_ff;
   assign rsp_neighbor_index = nb_ff;
   assign rsp_move_code      = mv_ff;
   assign rsp_has_edge       = edge_ff;
   assign rsp_index_error    = err_ff;
   assign rsp_last_result    = last_ff;

endmodule

// ----- sv/tetra_lattice_neighbor_enumerator_core.sv -----
// The front end unranks a request by scanning a-slabs and then b-rows, while an
// index out of range goes straight to the queue; it takes no new request until
// the last one has been pushed. The back end walks one move per cycle, unless the
// response side stalls, up to the last valid one and sets the pace when it is the slower side.
// Reset (synchronous, active high) empties the queue and output and sets depth to 0.
module tetra_lattice_neighbor_enumerator_core
   import tlne_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   // request channel
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [INDEX_W-1:0]   req_vertex_index,
   // response channel
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [DEPTH_W-1:0]   rsp_coord_a,
   output logic [DEPTH_W-1:0]   rsp_coord_b,
   output logic [DEPTH_W-1:0]   rsp_coord_c,
   output logic [DEPTH_W-1:0]   rsp_coord_d,
   output logic [INDEX_W-1:0]   rsp_neighbor_index,
   output logic [MOVE_W-1:0]    rsp_move_code,
   output logic                 rsp_has_edge,
   output logic                 rsp_index_error,
   output logic                 rsp_last_result,
   // depth register write
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [DEPTH_W-1:0]   csr_mesh_depth
);

   // Subdivision depth. A 6-bit value never exceeds the depth limit, so
   // no saturation is required.
   logic [DEPTH_W-1:0] depth_ff, depth_in;

   queue_port_type push;
   queue_port_type head;
   logic           queue_full;
   logic           pop;

   // Always take a register write transaction; it must only be issued while idle, which the block does not enforce.
   assign csr_ready = 1'b1;

   always_comb begin
      depth_in = depth_ff;
      if (csr_valid && csr_ready) begin
         depth_in = csr_mesh_depth;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff <= '0;
      end else begin
         depth_ff <= depth_in;
      end
   end

   // Front end: range-check the index, then unrank it by peeling whole
   // a-slabs (triangles) and b-rows (lines) one per cycle. The vertex
   // coordinates, its rank, and that rank plus the size of its a-slab go to the queue.
   tlne_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_vertex_index (req_vertex_index),
      .depth            (depth_ff),
      .queue_full       (queue_full),
      .push             (push)
   );

   // Two-entry queue: lets the front start on the next transaction while
   // the back end is still emitting or is held by the response side.
   tlne_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .full  (queue_full),
      .head  (head),
      .pop   (pop)
   );

   // Back end: walk the six moves, one per cycle unless the response side
   // stalls. Each neighbour rank is the source rank plus a small offset (plus
   // the slab size for moves that raise a), so a single adder serves every
   // move. Drop invalid moves, mark the last valid one, and hold the output
   // register while the response side stalls.
   tlne_back u_back (
      .clock              (clock),
      .reset              (reset),
      .head               (head),
      .pop                (pop),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_coord_a        (rsp_coord_a),
      .rsp_coord_b        (rsp_coord_b),
      .rsp_coord_c        (rsp_coord_c),
      .rsp_coord_d        (rsp_coord_d),
      .rsp_neighbor_index (rsp_neighbor_index),
      .rsp_move_code      (rsp_move_code),
      .rsp_has_edge       (rsp_has_edge),
      .rsp_index_error    (rsp_index_error),
      .rsp_last_result    (rsp_last_result)
   );

endmodule

// ----- sv/tlne_checker.sv -----
module tlne_checker
   import tlne_pkg::*;
(
   input logic                 clock,
   input logic                 reset,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input logic [DEPTH_W-1:0]   rsp_coord_a,
   input logic [DEPTH_W-1:0]   rsp_coord_b,
   input logic [DEPTH_W-1:0]   rsp_coord_c,
   input logic [DEPTH_W-1:0]   rsp_coord_d,
   input logic [INDEX_W-1:0]   rsp_neighbor_index,
   input logic [MOVE_W-1:0]    rsp_move_code,
   input logic                 rsp_has_edge,
   input logic                 rsp_index_error,
   input logic                 rsp_last_result
);

   // A stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_neighbor_index)
         && $stable(rsp_move_code) && $stable(rsp_last_result))
      else $error("stalled response changed");

   // An index error is a lone, edgeless result with zeroed fields
   a_err_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_index_error |-> rsp_last_result && !rsp_has_edge
         && rsp_coord_a == '0 && rsp_coord_b == '0 && rsp_coord_c == '0
         && rsp_coord_d == '0 && rsp_neighbor_index == '0)
      else $error("malformed index error response");

   // An edgeless result always closes its transaction
   a_noedge_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_has_edge |-> rsp_last_result && rsp_move_code == MOVE_AB)
      else $error("edgeless response not last");

   // Edges only carry legal move codes, and never an error
   a_edge_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_has_edge |-> !rsp_index_error && rsp_move_code <= MOVE_CD)
      else $error("edge with illegal move code");

endmodule

bind tetra_lattice_neighbor_enumerator_core tlne_checker u_checker (.*);

// ----- tb/tetra_lattice_neighbor_enumerator_core_tb.sv -----
module tetra_lattice_neighbor_enumerator_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import tlne_pkg::*;

   // Settle time before a depth write: long enough for the slab scan and the
   // back end to finish.
   localparam int SETTLE_CYCLES = 2 * MAX_DEPTH + 16;
   localparam int RANDOM_ITEMS  = 300;
   localparam int CYCLE_LIMIT   = 400000;

   // One response transaction as seen on the rsp_ port
   typedef struct packed {
      logic [DEPTH_W-1:0] coord_a;
      logic [DEPTH_W-1:0] coord_b;
      logic [DEPTH_W-1:0] coord_c;
      logic [DEPTH_W-1:0] coord_d;
      logic [INDEX_W-1:0] neighbor_index;
      logic [MOVE_W-1:0]  move_code;
      logic               has_edge;
      logic               index_error;
      logic               last_result;
   } neighbor_result_type;

   // Shapes of back pressure on the response channel
   typedef enum int {
      STALL_NONE,
      STALL_LIGHT,
      STALL_HEAVY,
      STALL_BLOCKS
   } stall_mode_type;

   localparam logic [MOVE_W-1:0] MOVE_ORDER [MOVE_COUNT] =
      '{MOVE_AB, MOVE_AC, MOVE_AD, MOVE_BC, MOVE_BD, MOVE_CD};

   logic                 clock;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [INDEX_W-1:0]   req_vertex_index = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [DEPTH_W-1:0]   rsp_coord_a;
   logic [DEPTH_W-1:0]   rsp_coord_b;
   logic [DEPTH_W-1:0]   rsp_coord_c;
   logic [DEPTH_W-1:0]   rsp_coord_d;
   logic [INDEX_W-1:0]   rsp_neighbor_index;
   logic [MOVE_W-1:0]    rsp_move_code;
   logic                 rsp_has_edge;
   logic                 rsp_index_error;
   logic                 rsp_last_result;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [DEPTH_W-1:0]   csr_mesh_depth = '0;

   // Expected responses, oldest first
   neighbor_result_type pending_edges [$];

   int unsigned     lattice_depth = 0;   // depth register as the predictor sees it
   int              mismatch_count = 0;
   int              cycle_count = 0;
   int              burst_left = 0;
   bit              req_held = 1'b0;     // req_valid kept high into the next transaction
   stall_mode_type  stall_mode = STALL_NONE;
   int              stall_span = 0;

   tetra_lattice_neighbor_enumerator_core dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_vertex_index   (req_vertex_index),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_coord_a        (rsp_coord_a),
      .rsp_coord_b        (rsp_coord_b),
      .rsp_coord_c        (rsp_coord_c),
      .rsp_coord_d        (rsp_coord_d),
      .rsp_neighbor_index (rsp_neighbor_index),
      .rsp_move_code      (rsp_move_code),
      .rsp_has_edge       (rsp_has_edge),
      .rsp_index_error    (rsp_index_error),
      .rsp_last_result    (rsp_last_result),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_mesh_depth     (csr_mesh_depth)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // Lattice arithmetic
   // ------------------------------------------------------------------

   // Points in a triangular slab of side r
   function automatic int unsigned slab_points(input int unsigned r);
      return (r + 2) * (r + 1) / 2;
   endfunction

   // Points in the whole tetrahedron of depth d
   function automatic int unsigned vertex_count(input int unsigned d);
      return (d + 3) * (d + 2) * (d + 1) / 6;
   endfunction

   // Linear index of (a,b,c,*) in slab order: a outermost, then b, then c
   function automatic int unsigned rank_vertex(input int unsigned d, input int unsigned a,
                                               input int unsigned b, input int unsigned c);
      int unsigned idx;
      idx = 0;
      for (int unsigned k = 0; k < a; k++) idx += slab_points(d - k);
      for (int unsigned k = 0; k < b; k++) idx += d - a - k + 1;
      return idx + c;
   endfunction

   // Work out every response one vertex index causes at the current depth and
   // queue them in the order the block must send them.
   task automatic predict_neighbors(input logic [INDEX_W-1:0] idx);
      int unsigned          d;
      int unsigned          rest;
      int unsigned          rem;
      int unsigned          pt [4];
      int unsigned          nb [4];
      int                   gain;
      int                   lose;
      neighbor_result_type  res;
      neighbor_result_type  batch [$];
      d = (lattice_depth > MAX_DEPTH) ? MAX_DEPTH : lattice_depth;
      res = '0;
      // Out of range: a single flagged response with everything else cleared
      if (idx >= vertex_count(d)) begin
         res.index_error = 1'b1;
         res.last_result = 1'b1;
         pending_edges.push_back(res);
         return;
      end
      // Peel off whole slabs, then whole rows, and what is left is c
      rest = idx;
      pt[0] = 0;
      while (rest >= slab_points(d - pt[0])) begin
         rest -= slab_points(d - pt[0]);
         pt[0]++;
      end
      rem = d - pt[0];
      pt[1] = 0;
      while (rest >= rem - pt[1] + 1) begin
         rest -= rem - pt[1] + 1;
         pt[1]++;
      end
      pt[2] = rest;
      pt[3] = rem - pt[1] - pt[2];
      res.coord_a = DEPTH_W'(pt[0]);
      res.coord_b = DEPTH_W'(pt[1]);
      res.coord_c = DEPTH_W'(pt[2]);
      res.coord_d = DEPTH_W'(pt[3]);
      foreach (MOVE_ORDER[m]) begin
         case (MOVE_ORDER[m])
            MOVE_AB: begin gain = 0; lose = 1; end
            MOVE_AC: begin gain = 0; lose = 2; end
            MOVE_AD: begin gain = 0; lose = 3; end
            MOVE_BC: begin gain = 1; lose = 2; end
            MOVE_BD: begin gain = 1; lose = 3; end
            default: begin gain = 2; lose = 3; end
         endcase
         // Skip a move that would drive a coordinate negative
         if (pt[lose] != 0) begin
            nb = pt;
            nb[gain]++;
            nb[lose]--;
            res.neighbor_index = INDEX_W'(rank_vertex(d, nb[0], nb[1], nb[2]));
            res.move_code      = MOVE_ORDER[m];
            res.has_edge       = 1'b1;
            batch.push_back(res);
         end
      end
      // No move at all (depth zero, or the a corner): one bare response
      if (batch.size() == 0) begin
         res.last_result = 1'b1;
         pending_edges.push_back(res);
         return;
      end
      batch[batch.size() - 1].last_result = 1'b1;
      foreach (batch[i]) pending_edges.push_back(batch[i]);
   endtask

   // ------------------------------------------------------------------
   // Request side
   // ------------------------------------------------------------------

   // Send one vertex index. Valid stays high across a burst; at the end of a
   // burst it drops in the same step as the last accepted transaction, and a
   // fresh burst starts only after an idle gap with valid low.
   task automatic send_vertex(input logic [INDEX_W-1:0] idx);
      if (!req_held) begin
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? 1 : $urandom_range(2, 24);
         req_valid <= 1'b1;
         req_held = 1'b1;
      end
      req_vertex_index <= idx;
      predict_neighbors(idx);
      @(posedge clock);
      while (req_stall) @(posedge clock);
      burst_left--;
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         req_held = 1'b0;
      end
   endtask

   // Close any open burst; call only straight after send_vertex returns
   task automatic close_burst();
      if (req_held) begin
         req_valid <= 1'b0;
         req_held = 1'b0;
      end
   endtask

   // Let every expected response drain, then let the block settle
   task automatic wait_idle();
      close_burst();
      while (pending_edges.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write the depth register once the block has gone quiet
   task automatic write_depth(input int unsigned depth_value);
      wait_idle();
      csr_valid      <= 1'b1;
      csr_mesh_depth <= DEPTH_W'(depth_value);
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      lattice_depth = depth_value;
   endtask

   // ------------------------------------------------------------------
   // Response side: compare each transaction, then choose the next stall
   // ------------------------------------------------------------------

   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatch_count++;
      end
   endtask

   task automatic check_response();
      neighbor_result_type want;
      if (pending_edges.size() == 0) begin
         $error("response with nothing expected: neighbor_index %0d move_code %0d",
                rsp_neighbor_index, rsp_move_code);
         mismatch_count++;
         return;
      end
      want = pending_edges.pop_front();
      check_field("coord_a", want.coord_a, rsp_coord_a);
      check_field("coord_b", want.coord_b, rsp_coord_b);
      check_field("coord_c", want.coord_c, rsp_coord_c);
      check_field("coord_d", want.coord_d, rsp_coord_d);
      check_field("neighbor_index", want.neighbor_index, rsp_neighbor_index);
      check_field("move_code", want.move_code, rsp_move_code);
      check_field("has_edge", want.has_edge, rsp_has_edge);
      check_field("index_error", want.index_error, rsp_index_error);
      check_field("last_result", want.last_result, rsp_last_result);
   endtask

   // Sample at the edge, before this step's updates land, then pick the stall
   // for the next cycle. The stall shape changes from span to span, and
   // some spans hold no stall at all.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) check_response();
      if (stall_span == 0) begin
         stall_mode = stall_mode_type'($urandom_range(0, 3));
         stall_span = $urandom_range(8, 80);
      end
      stall_span--;
      case (stall_mode)
         STALL_NONE:  rsp_stall <= 1'b0;
         STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
         STALL_HEAVY: rsp_stall <= ($urandom_range(0, 9) < 6);
         default:     rsp_stall <= ((stall_span / 3) % 2 == 1);
      endcase
   end

   // Watchdog: abandon a run that hangs
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Depth zero straight out of reset: the lone point, and indexes past it
   task automatic test_reset_depth();
      send_vertex(16'h0000);
      send_vertex(16'h0001);
      send_vertex(16'hFFFF);
   endtask

   // Depth one: all four corners plus the first index past the end
   task automatic test_depth_one();
      write_depth(1);
      for (int i = 0; i <= 4; i++) send_vertex(INDEX_W'(i));
   endtask

   // Small depth: an inner point with all six moves open, the a corner, a point
   // on the b-c-d face, one on the a-c edge and the final out-of-range index
   task automatic test_small_interior();
      write_depth(3);
      send_vertex(INDEX_W'(rank_vertex(3, 0, 1, 1)));
      send_vertex(INDEX_W'(rank_vertex(3, 3, 0, 0)));
      send_vertex(INDEX_W'(rank_vertex(3, 0, 0, 3)));
      send_vertex(INDEX_W'(rank_vertex(3, 1, 0, 2)));
      send_vertex(INDEX_W'(vertex_count(3)));
   endtask

   // Deepest lattice: first and last points, the boundary, all ones, an
   // inner point with large coordinates, and the c and b corners
   task automatic test_full_depth();
      write_depth(MAX_DEPTH);
      send_vertex(16'h0000);
      send_vertex(INDEX_W'(vertex_count(MAX_DEPTH) - 1));
      send_vertex(INDEX_W'(vertex_count(MAX_DEPTH)));
      send_vertex(16'hFFFF);
      send_vertex(INDEX_W'(rank_vertex(MAX_DEPTH, 10, 20, 15)));
      send_vertex(INDEX_W'(rank_vertex(MAX_DEPTH, 0, 0, MAX_DEPTH)));
      send_vertex(INDEX_W'(rank_vertex(MAX_DEPTH, 0, MAX_DEPTH, 0)));
   endtask

   // Random phases: a new depth each phase, mostly valid indexes with a
   // sprinkling of out-of-range ones
   task automatic test_random_lattices();
      int          sent;
      int          phase_len;
      int unsigned d;
      int unsigned total;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         case ($urandom_range(0, 5))
            0:       d = MAX_DEPTH;
            1:       d = $urandom_range(0, 3);
            default: d = $urandom_range(0, MAX_DEPTH);
         endcase
         write_depth(d);
         total = vertex_count(d);
         phase_len = $urandom_range(10, 40);
         for (int i = 0; i < phase_len; i++) begin
            if ($urandom_range(0, 9) == 0)
               send_vertex(INDEX_W'($urandom_range(total, 16'hFFFF)));
            else
               send_vertex(INDEX_W'($urandom_range(0, total - 1)));
         end
         sent += phase_len;
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_depth();
      test_depth_one();
      test_small_interior();
      test_full_depth();
      test_random_lattices();
      // Drain, then watch a while longer for stray transactions
      wait_idle();
      if (mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
